// ===== src/keypad_change_event_scanner_defines.svh =====
`ifndef KEYPAD_CHANGE_EVENT_SCANNER_DEFINES_SVH
`define KEYPAD_CHANGE_EVENT_SCANNER_DEFINES_SVH

// Both macros expect clk and rst_n to be visible where they are used.

// The consequent must hold in the same cycle as the antecedent.
`define KCES_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kces_pkg.sv =====
package kces_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int NOW_W        = 32;
    localparam int DEBOUNCE_W   = 16;
    localparam int DIM_REG_W    = 3;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 8;
    localparam int KEY_FIELD_W  = 2;

    localparam int DEF_MAX_ROWS = 4;
    localparam int DEF_MAX_COLS = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS     = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd10;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MIN = 16'd1;
    localparam logic [DIM_REG_W-1:0]  ROWS_RST     = 3'd4;
    localparam logic [DIM_REG_W-1:0]  COLS_RST     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK
    } scan_state_t;

    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] sample;
    } walk_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } walk_status_t;

endpackage

// ===== src/kces_walker.sv =====
module kces_walker #(
    parameter int MAX_ROWS = kces_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = kces_pkg::DEF_MAX_COLS,
    localparam int RDIM_W  = $clog2(MAX_ROWS + 1),
    localparam int CDIM_W  = $clog2(MAX_COLS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kces_pkg::walk_ctrl_t                ctrl,
    output kces_pkg::walk_status_t              status,
    input  logic [RDIM_W-1:0]                   rows_eff,
    input  logic [CDIM_W-1:0]                   cols_eff,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields from bit 0: key_row[1:0], key_col[3:2], pressed[4], zero pad [7:5]
    output logic [kces_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // m_tlast carries last_event
    output logic                                m_tlast
);
    import kces_pkg::*;

    localparam int KEY_SLOTS  = MAX_ROWS * MAX_COLS;
    localparam int STATE_BITS = (KEY_SLOTS < SAMPLE_BITS) ? KEY_SLOTS : SAMPLE_BITS;
    localparam int STEP_W     = (STATE_BITS > 1) ? $clog2(STATE_BITS) : 1;
    localparam int RIDX_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIDX_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Stored key states rotate once round per scan, so the key under test is always bit 0.
    logic [STATE_BITS-1:0] state_reg, state_next;
    logic [STATE_BITS-1:0] samp_reg, samp_next;
    logic [STATE_BITS-1:0] diff_reg, diff_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [RIDX_W-1:0]     row_reg, row_next;
    logic [CIDX_W-1:0]     col_reg, col_next;
    logic                  busy_reg, busy_next;

    logic                  out_valid_reg, out_valid_next;
    logic [RIDX_W-1:0]     out_row_reg, out_row_next;
    logic [CIDX_W-1:0]     out_col_reg, out_col_next;
    logic                  out_pressed_reg, out_pressed_next;
    logic                  out_last_reg, out_last_next;

    logic [STATE_BITS-1:0] active_mask;
    logic [STATE_BITS-1:0] diff_rest;
    logic                  advance;
    logic                  final_step;
    logic [RIDX_W+1:0]     row_ext;
    logic [CIDX_W+1:0]     col_ext;

    always_comb
    begin
        for (int i = 0; i < STATE_BITS; i++)
        begin
            active_mask[i] = (i < int'(rows_eff) * int'(cols_eff));
        end
    end

    assign advance    = busy_reg && (!out_valid_reg || m_tready);
    assign final_step = (step_reg == STEP_W'(STATE_BITS - 1));
    assign diff_rest  = diff_reg >> 1;

    always_comb
    begin
        state_next       = state_reg;
        samp_next        = samp_reg;
        diff_next        = diff_reg;
        step_next        = step_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        busy_next        = busy_reg;
        out_valid_next   = out_valid_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_pressed_next = out_pressed_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.start)
        begin
            samp_next = ctrl.sample[STATE_BITS-1:0];
            diff_next = (ctrl.sample[STATE_BITS-1:0] ^ state_reg) & active_mask;
            step_next = '0;
            row_next  = '0;
            col_next  = '0;
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            if (diff_reg[0])
            begin
                out_valid_next   = 1'b1;
                out_row_next     = row_reg;
                out_col_next     = col_reg;
                out_pressed_next = samp_reg[0];
                out_last_next    = (diff_rest == '0);
            end
            state_next = (state_reg >> 1)
                       | (STATE_BITS'(state_reg[0] ^ diff_reg[0]) << (STATE_BITS - 1));
            samp_next  = samp_reg >> 1;
            diff_next  = diff_rest;
            step_next  = step_reg + 1'b1;
            if (int'(col_reg) == int'(cols_eff) - 1)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
            if (final_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            step_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg        <= samp_next;
        diff_reg        <= diff_next;
        out_row_reg     <= out_row_next;
        out_col_reg     <= out_col_next;
        out_pressed_reg <= out_pressed_next;
        out_last_reg    <= out_last_next;
    end

    assign row_ext = {2'b00, out_row_reg};
    assign col_ext = {2'b00, out_col_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pressed_reg,
                       col_ext[KEY_FIELD_W-1:0], row_ext[KEY_FIELD_W-1:0]};
    assign m_tlast  = out_last_reg;

    assign status.busy = busy_reg;
    assign status.done = advance && final_step;

endmodule

// ===== src/keypad_change_event_scanner.sv =====
// Accepts one transaction when idle, then checks the elapsed time in the CHECK state.
// A due scan then walks the key state shift register one key per cycle while the output
// is not stalled, over min(16, rows*cols of the build) key positions; no new transaction
// is taken until the walk ends. Each changed key in the walk yields one event.
// Output stalls pause the walk. Asynchronous active-low reset clears all key states,
// the last scan time, and restores debounce 10 ms with a 4 by 4 geometry.
`include "keypad_change_event_scanner_defines.svh"

module keypad_change_event_scanner #(
    parameter int MAX_ROWS = kces_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = kces_pkg::DEF_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kces_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [kces_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata fields from bit 0: now_ms[31:0], key_sample[47:32]
    input  logic [kces_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields from bit 0: key_row[1:0], key_col[3:2], pressed[4], zero pad [7:5]
    output logic [kces_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // m_tlast carries last_event
    output logic                                m_tlast
);
    import kces_pkg::*;

    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);

    scan_state_t state_reg, state_next;

    logic [DEBOUNCE_W-1:0]  debounce_ms_reg, debounce_ms_next;
    logic [DIM_REG_W-1:0]   rows_in_use_reg, rows_in_use_next;
    logic [DIM_REG_W-1:0]   cols_in_use_reg, cols_in_use_next;
    logic [NOW_W-1:0]       last_scan_reg, last_scan_next;
    logic [NOW_W-1:0]       now_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic [NOW_W-1:0]       elapsed;
    logic                   scan_due;
    logic [RDIM_W-1:0]      rows_eff;
    logic [CDIM_W-1:0]      cols_eff;
    walk_ctrl_t             walk_ctrl;
    walk_status_t           walk_status;

    always_comb
    begin
        debounce_ms_next = debounce_ms_reg;
        rows_in_use_next = rows_in_use_reg;
        cols_in_use_next = cols_in_use_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEBOUNCE:
                begin
                    debounce_ms_next = (cfg_wdata[DEBOUNCE_W-1:0] == '0)
                                     ? DEBOUNCE_MIN : cfg_wdata[DEBOUNCE_W-1:0];
                end
                CFG_ROWS: rows_in_use_next = cfg_wdata[DIM_REG_W-1:0];
                CFG_COLS: cols_in_use_next = cfg_wdata[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero is taken as one, anything above the build's limit saturates.
    always_comb
    begin
        if (rows_in_use_reg == '0)
            rows_eff = RDIM_W'(1);
        else if (int'(rows_in_use_reg) > MAX_ROWS)
            rows_eff = RDIM_W'(MAX_ROWS);
        else
            rows_eff = RDIM_W'(rows_in_use_reg);

        if (cols_in_use_reg == '0)
            cols_eff = CDIM_W'(1);
        else if (int'(cols_in_use_reg) > MAX_COLS)
            cols_eff = CDIM_W'(MAX_COLS);
        else
            cols_eff = CDIM_W'(cols_in_use_reg);
    end

    assign elapsed  = now_reg - last_scan_reg;
    assign scan_due = (elapsed > {{(NOW_W - DEBOUNCE_W){1'b0}}, debounce_ms_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = scan_due ? ST_WALK : ST_IDLE;
            end
            ST_WALK:
            begin
                if (walk_status.done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready         = 1'b0;
        walk_ctrl.start  = 1'b0;
        walk_ctrl.sample = sample_reg;
        last_scan_next   = last_scan_reg;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_CHECK:
            begin
                if (scan_due)
                begin
                    walk_ctrl.start = 1'b1;
                    last_scan_next  = now_reg;
                end
            end
            ST_WALK:  ;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            debounce_ms_reg <= DEBOUNCE_RST;
            rows_in_use_reg <= ROWS_RST;
            cols_in_use_reg <= COLS_RST;
            last_scan_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            debounce_ms_reg <= debounce_ms_next;
            rows_in_use_reg <= rows_in_use_next;
            cols_in_use_reg <= cols_in_use_next;
            last_scan_reg   <= last_scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            now_reg    <= s_tdata[NOW_W-1:0];
            sample_reg <= s_tdata[NOW_W +: SAMPLE_BITS];
        end
    end

    kces_walker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (walk_ctrl),
        .status   (walk_status),
        .rows_eff (rows_eff),
        .cols_eff (cols_eff),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `KCES_ASSERT_NEXT(a_accept_checks, s_tvalid && s_tready, state_reg == ST_CHECK,
        "accepted transaction did not move to the time check")
    `KCES_ASSERT_NEXT(a_start_busy, walk_ctrl.start, walk_status.busy && state_reg == ST_WALK,
        "scan start did not set the walker busy")
    `KCES_ASSERT_SAME(a_idle_walker, state_reg == ST_IDLE || state_reg == ST_CHECK,
        !walk_status.busy, "walker busy while the controller is not walking")
    `KCES_ASSERT_NEXT(a_done_idle, walk_status.done, !walk_status.busy && state_reg == ST_IDLE,
        "walk finished but controller or walker did not return to idle")

endmodule

// ===== bench/kces_event_checker.sv =====
`timescale 1ns / 100ps

module kces_event_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kces_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [kces_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [kces_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [kces_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tlast,
    output int                                  mismatches,
    output int                                  outstanding
);
    import kces_pkg::*;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic       pressed;
        logic       last;
    } key_change_t;

    key_change_t                 due_changes[$];
    key_change_t                 head;
    logic [SAMPLE_BITS-1:0]      key_down;
    logic [NOW_W-1:0]            last_scan_ms;
    logic [DEBOUNCE_W-1:0]       debounce_ms;
    logic [DIM_REG_W-1:0]        rows_reg;
    logic [DIM_REG_W-1:0]        cols_reg;
    int                          fail_count = 0;

    // Works out the change events caused by one input transaction and queues them.
    task automatic scan_keys(input logic [NOW_W-1:0] now_ms,
                             input logic [SAMPLE_BITS-1:0] sample);
        logic [NOW_W-1:0]       elapsed;
        logic [SAMPLE_BITS-1:0] changed;
        int                     rows;
        int                     cols;
        int                     idx;
        int                     total;
        int                     emitted;
        key_change_t            chg;
        begin
            elapsed = now_ms - last_scan_ms;
            if (elapsed <= {16'd0, debounce_ms})
                return;
            last_scan_ms = now_ms;
            rows = (rows_reg == 0) ? 1 : (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_reg;
            cols = (cols_reg == 0) ? 1 : (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_reg;
            // First pass finds the changed keys so that the final one can carry tlast.
            changed = '0;
            total = 0;
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                begin
                    idx = r * cols + c;
                    if (idx < SAMPLE_BITS && sample[idx] != key_down[idx])
                    begin
                        changed[idx] = 1'b1;
                        total++;
                    end
                end
            emitted = 0;
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                begin
                    idx = r * cols + c;
                    if (idx < SAMPLE_BITS && changed[idx])
                    begin
                        key_down[idx] = sample[idx];
                        chg.row     = r[1:0];
                        chg.col     = c[1:0];
                        chg.pressed = sample[idx];
                        chg.last    = (emitted == total - 1);
                        due_changes.push_back(chg);
                        emitted++;
                    end
                end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_changes.delete();
            key_down     = '0;
            last_scan_ms = '0;
            debounce_ms  = DEBOUNCE_RST;
            rows_reg     = ROWS_RST;
            cols_reg     = COLS_RST;
            mismatches  <= fail_count;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_DEBOUNCE: debounce_ms = (cfg_wdata == '0) ? DEBOUNCE_MIN : cfg_wdata;
                    CFG_ROWS:     rows_reg = cfg_wdata[DIM_REG_W-1:0];
                    CFG_COLS:     cols_reg = cfg_wdata[DIM_REG_W-1:0];
                    default:      ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (due_changes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected event, tdata %h tlast %b",
                                 $realtime, m_tdata, m_tlast);
                end
                else
                begin
                    head = due_changes.pop_front();
                    if (m_tdata[1:0] != head.row || m_tdata[3:2] != head.col
                        || m_tdata[4] != head.pressed || m_tdata[7:5] != 3'b000
                        || m_tlast != head.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: event mismatch, expected row %0d col %0d ",
                                      "pressed %b last %b, got row %0d col %0d pressed %b ",
                                      "pad %b last %b"},
                                     $realtime, head.row, head.col, head.pressed, head.last,
                                     m_tdata[1:0], m_tdata[3:2], m_tdata[4], m_tdata[7:5],
                                     m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                scan_keys(s_tdata[NOW_W-1:0], s_tdata[NOW_W+SAMPLE_BITS-1:NOW_W]);
            mismatches  <= fail_count;
            outstanding <= due_changes.size();
        end
    end

endmodule

// ===== bench/tb_keypad_change_event_scanner.sv =====
`timescale 1ns / 100ps

module tb_keypad_change_event_scanner;
    import kces_pkg::*;

    // Index 3 decodes to no register; writes to it must change nothing.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 60;
    localparam int PHASES          = 6;
    localparam int DIRECTED_ITEMS  = 14;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]      cfg_addr = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // s_tdata fields from bit 0: now_ms[31:0], key_sample[47:32]
    logic [IN_TDATA_W-1:0]      s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // m_tdata fields from bit 0: key_row[1:0], key_col[3:2], pressed[4], zero pad [7:5]
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic                       m_tlast;

    int                         mismatches;
    int                         outstanding;
    int                         debounce_eff = DEBOUNCE_RST;
    bit                         steady = 1'b0;
    bit                         hold_off_go = 1'b0;

    always #4 clk = ~clk;

    keypad_change_event_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    kces_event_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        #4_000_000;
        $display("tb_keypad_change_event_scanner: done, errors");
        $finish;
    end

    // Event receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    task automatic send_item(input logic [NOW_W-1:0] t, input logic [SAMPLE_BITS-1:0] k);
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {k, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == CFG_DEBOUNCE)
            debounce_eff = (val == '0) ? 1 : int'(val);
    endtask

    // Lets every queued event drain and the walk finish before registers change.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [NOW_W-1:0]       dir_ms [DIRECTED_ITEMS];
        logic [SAMPLE_BITS-1:0] dir_keys [DIRECTED_ITEMS];
        logic [NOW_W-1:0]       now_ms;
        logic [SAMPLE_BITS-1:0] sample;
        int                     pick;
        int                     wait_cycles;

        // Debounce 10 at reset: boundaries at exactly 10, a full press and release,
        // a scan with no change, and a scan across the 32-bit wrap.
        dir_ms = '{32'd0, 32'd10, 32'd11, 32'd15, 32'd22, 32'd34, 32'd46, 32'd58,
                   32'd70, 32'd82, 32'hFFFF_FFF0, 32'h0000_0005, 32'h0000_000F,
                   32'h0000_0010};
        dir_keys = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                     16'h8001, 16'hAAAA, 16'h5555, 16'h5555, 16'h1234, 16'hFFFF,
                     16'h0000, 16'h0000};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ITEMS; i++)
            send_item(dir_ms[i], dir_keys[i]);
        now_ms = dir_ms[DIRECTED_ITEMS-1];
        sample = '0;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            steady = 1'b0;
            case (phase)
                0:
                begin
                    set_register(CFG_DEBOUNCE, 16'd0);
                    set_register(CFG_ROWS, 16'd4);
                    set_register(CFG_COLS, 16'd4);
                end
                1:
                begin
                    set_register(CFG_DEBOUNCE, 16'hFFFF);
                    set_register(CFG_ROWS, 16'd3);
                    set_register(CFG_COLS, 16'd2);
                end
                2:
                begin
                    set_register(CFG_DEBOUNCE, 16'd3);
                    set_register(CFG_ROWS, 16'd0);
                    set_register(CFG_COLS, 16'd7);
                end
                3:
                begin
                    set_register(CFG_DEBOUNCE, 16'($urandom_range(1, 200)));
                    set_register(CFG_ROWS, 16'd7);
                    set_register(CFG_COLS, 16'd0);
                end
                4:
                begin
                    set_register(CFG_DEBOUNCE, 16'd10);
                    set_register(CFG_ROWS, 16'hFFF9);
                    set_register(CFG_COLS, 16'd1);
                    set_register(CFG_SPARE, 16'($urandom()));
                end
                default:
                begin
                    set_register(CFG_DEBOUNCE, 16'($urandom()));
                    set_register(CFG_ROWS, 16'($urandom()));
                    set_register(CFG_COLS, 16'($urandom()));
                end
            endcase
            cfg_we <= 1'b0;
            // The first phase runs without idling and with the receiver held off,
            // so the scanner fills up and has to stall its input.
            if (phase == 0)
            begin
                steady = 1'b1;
                hold_off_go = 1'b1;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    now_ms += debounce_eff + 1 + $urandom_range(0, 40);
                else if (pick < 72)
                    now_ms += $urandom_range(0, debounce_eff);
                else if (pick < 82)
                    now_ms += debounce_eff;
                else if (pick < 92)
                    now_ms = $urandom();
                else
                    now_ms += debounce_eff + 1;

                pick = $urandom_range(0, 9);
                if (pick < 4)
                    sample = 16'($urandom());
                else if (pick < 7)
                    sample ^= (16'd1 << $urandom_range(0, 15))
                              | (16'($urandom_range(0, 1)) << $urandom_range(0, 15));
                else if (pick == 8)
                    sample = '1;
                else if (pick == 9)
                    sample = '0;

                send_item(now_ms, sample);
            end
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        @(posedge clk);
        for (wait_cycles = 0; outstanding != 0 && wait_cycles < 20000; wait_cycles++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb_keypad_change_event_scanner: done, clean");
        else
            $display("tb_keypad_change_event_scanner: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/kces_pkg.sv
src/kces_walker.sv
src/keypad_change_event_scanner.sv
bench/kces_event_checker.sv
bench/tb_keypad_change_event_scanner.sv
